/* design/wav_header_chunk_parser_assert.svh */
// Assertion macros for the WAV header parser.
// Included by whcp_parse; the top level uses its macros too. No other dependencies.
`ifndef WAV_HEADER_CHUNK_PARSER_ASSERT_SVH
`define WAV_HEADER_CHUNK_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define WHCP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("whcp assertion failed");
`define WHCP_ASSERT_NEVER(lbl, clk, rstn, expr) \
	`WHCP_ASSERT(lbl, clk, rstn, !(expr))
`else
`define WHCP_ASSERT(lbl, clk, rstn, prop)
`define WHCP_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* design/whcp_pkg.sv */
// Shared types and constants for the WAV header parser.
// No dependencies; used by every module of the block.
`default_nettype none
package whcp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] MIN_FILE_SIZE = 32'd44;
	localparam logic [31:0] MIN_FMT_SIZE  = 32'd16;
	localparam logic [31:0] POS_RIFF_END  = 32'd3;
	localparam logic [31:0] POS_WAVE_END  = 32'd11;
	localparam logic [32:0] FIRST_CHUNK   = 33'd12;
	localparam logic [32:0] HDR_LEN       = 33'd8;
	localparam logic [32:0] HDR_TAG_LEN   = 33'd4;
	localparam logic [32:0] HDR_LAST      = 33'd7;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_SMALL      = 4'd1;
	localparam logic [3:0] ST_NO_RIFF    = 4'd2;
	localparam logic [3:0] ST_NO_WAVE    = 4'd3;
	localparam logic [3:0] ST_FMT_SHORT  = 4'd4;
	localparam logic [3:0] ST_FMT_RANGE  = 4'd5;
	localparam logic [3:0] ST_DATA_EARLY = 4'd6;
	localparam logic [3:0] ST_DATA_RANGE = 4'd7;
	localparam logic [3:0] ST_MISSING    = 4'd8;
	localparam logic [3:0] ST_NOT_PCM    = 4'd9;

	localparam logic [15:0] FMT_PCM = 16'd1;

	localparam int OUT_W = 152;

	typedef enum logic [4:0] {
		PH_RIFF = 5'b00001,
		PH_HDR  = 5'b00010,
		PH_FMT  = 5'b00100,
		PH_SKIP = 5'b01000,
		PH_DONE = 5'b10000
	} whcp_phase_t;

	typedef struct packed {
		logic       last_byte;
		logic [7:0] data_byte;
	} whcp_item_t;

	typedef struct packed {
		logic [31:0] data_length;
		logic [31:0] data_offset;
		logic [15:0] sample_bits;
		logic [31:0] sample_rate;
		logic [15:0] channel_count;
		logic [15:0] audio_format;
		logic [3:0]  status;
	} whcp_result_t;

endpackage
`default_nettype wire

/* design/whcp_in_reg.sv */
// Input register stage of the WAV header parser.
// Depends on whcp_pkg for the request type.
`default_nettype none
module whcp_in_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [7:0]          s_tdata,   // data_byte [7:0]
	input  wire                 s_tlast,   // last_byte
	input  wire                 take,
	output logic                valid_s1,
	output whcp_pkg::whcp_item_t item_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_byte <= s_tdata;
			item_s1.last_byte <= s_tlast;
		end
	end

endmodule
`default_nettype wire

/* design/whcp_parse.sv */
// Parser state and per-byte decision logic of the WAV header parser.
// Depends on whcp_pkg and the assertion macro header.
`default_nettype none
`include "wav_header_chunk_parser_assert.svh"
module whcp_parse (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   take,
	input  whcp_pkg::whcp_item_t  item,
	input  wire  [31:0]           bsize,
	output logic                  res_valid,
	output whcp_pkg::whcp_result_t res
);

	whcp_pkg::whcp_phase_t phase_q, n_phase, ph;
	logic [31:0] pos_q, n_pos;
	logic [31:0] tag_q, n_tag;
	logic [31:0] size_q, n_size;
	logic [32:0] cend_q, n_cend;
	logic [32:0] body_q, n_body;
	logic        fmt_seen_q, n_fmt_seen;
	logic        given_q, n_given;
	logic [15:0] afmt_q, n_afmt;
	logic [15:0] chans_q, n_chans;
	logic [31:0] rate_q, n_rate;
	logic [15:0] bits_q, n_bits;

	logic [7:0]  b;
	logic [31:0] tag_sh, size_sh;
	logic [33:0] diff;
	logic        pos_ge;
	logic [32:0] k;
	logic [32:0] rel;
	logic        rel_small;
	logic        hdr_fits;
	logic [32:0] body;
	logic [33:0] chunk_stop;
	logic        stop_over;
	logic        active;

	assign b         = item.data_byte;
	assign tag_sh    = {tag_q[23:0], b};
	assign size_sh   = {b, size_q[31:8]};
	assign diff      = {2'b00, pos_q} - {1'b0, cend_q};
	assign pos_ge    = !diff[33];
	assign k         = diff[32:0];
	assign rel       = {1'b0, pos_q} - body_q;
	assign rel_small = (rel[32:4] == '0);
	assign hdr_fits  = ({1'b0, cend_q} + {1'b0, whcp_pkg::HDR_LEN}) <= {2'b00, bsize};
	assign body      = cend_q + whcp_pkg::HDR_LEN;
	assign chunk_stop = {1'b0, body} + {2'b00, size_sh};
	assign stop_over = chunk_stop > {2'b00, bsize};
	assign active    = !given_q && (phase_q != whcp_pkg::PH_DONE) && (pos_q < bsize);

	always_comb begin
		n_phase    = phase_q;
		n_pos      = pos_q;
		n_tag      = tag_q;
		n_size     = size_q;
		n_cend     = cend_q;
		n_body     = body_q;
		n_fmt_seen = fmt_seen_q;
		n_given    = given_q;
		n_afmt     = afmt_q;
		n_chans    = chans_q;
		n_rate     = rate_q;
		n_bits     = bits_q;
		res_valid  = 1'b0;
		res        = '0;
		ph         = phase_q;

		if (take && active) begin
			case (phase_q)
				whcp_pkg::PH_RIFF: begin
					if (pos_q == '0 && bsize < whcp_pkg::MIN_FILE_SIZE) begin
						res_valid  = 1'b1;
						res.status = whcp_pkg::ST_SMALL;
					end else begin
						n_tag = tag_sh;
						if (pos_q == whcp_pkg::POS_RIFF_END && tag_sh != whcp_pkg::TAG_RIFF) begin
							res_valid  = 1'b1;
							res.status = whcp_pkg::ST_NO_RIFF;
						end else if (pos_q == whcp_pkg::POS_WAVE_END) begin
							if (tag_sh != whcp_pkg::TAG_WAVE) begin
								res_valid  = 1'b1;
								res.status = whcp_pkg::ST_NO_WAVE;
							end else begin
								n_cend  = whcp_pkg::FIRST_CHUNK;
								n_phase = whcp_pkg::PH_SKIP;
							end
						end
					end
				end
				default: begin
					// chunk boundary reached: next header only if it fits in the buffer
					if ((ph == whcp_pkg::PH_FMT || ph == whcp_pkg::PH_SKIP) && pos_ge) begin
						ph = hdr_fits ? whcp_pkg::PH_HDR : whcp_pkg::PH_DONE;
					end
					n_phase = ph;
					if (ph == whcp_pkg::PH_FMT && rel_small) begin
						case (rel[3:0])
							4'd0:    n_afmt[7:0]   = b;
							4'd1:    n_afmt[15:8]  = b;
							4'd2:    n_chans[7:0]  = b;
							4'd3:    n_chans[15:8] = b;
							4'd4:    n_rate[7:0]   = b;
							4'd5:    n_rate[15:8]  = b;
							4'd6:    n_rate[23:16] = b;
							4'd7:    n_rate[31:24] = b;
							4'd14:   n_bits[7:0]   = b;
							4'd15:   n_bits[15:8]  = b;
							default: n_bits        = bits_q;
						endcase
					end else if (ph == whcp_pkg::PH_HDR) begin
						if (k < whcp_pkg::HDR_TAG_LEN) begin
							n_tag = tag_sh;
						end else begin
							n_size = size_sh;
						end
						if (k == whcp_pkg::HDR_LAST) begin
							if (tag_q == whcp_pkg::TAG_FMT) begin
								if (size_sh < whcp_pkg::MIN_FMT_SIZE) begin
									res_valid  = 1'b1;
									res.status = whcp_pkg::ST_FMT_SHORT;
								end else if (stop_over) begin
									res_valid  = 1'b1;
									res.status = whcp_pkg::ST_FMT_RANGE;
								end else begin
									n_fmt_seen = 1'b1;
									n_cend     = chunk_stop[32:0];
									n_body     = body;
									n_phase    = whcp_pkg::PH_FMT;
								end
							end else if (tag_q == whcp_pkg::TAG_DATA) begin
								res_valid = 1'b1;
								if (!fmt_seen_q) begin
									res.status = whcp_pkg::ST_DATA_EARLY;
								end else if (stop_over) begin
									res.status = whcp_pkg::ST_DATA_RANGE;
								end else begin
									res.status = (afmt_q == whcp_pkg::FMT_PCM) ?
										whcp_pkg::ST_OK : whcp_pkg::ST_NOT_PCM;
									res.audio_format  = afmt_q;
									res.channel_count = chans_q;
									res.sample_rate   = rate_q;
									res.sample_bits   = bits_q;
									res.data_offset   = body[31:0];
									res.data_length   = size_sh;
								end
							end else begin
								n_cend  = chunk_stop[32:0];
								n_phase = whcp_pkg::PH_SKIP;
							end
						end
					end
				end
			endcase
			if (res_valid) begin
				n_given = 1'b1;
				n_phase = whcp_pkg::PH_DONE;
			end
		end

		if (take) begin
			if (pos_q != '1) begin
				n_pos = pos_q + 32'd1;
			end
			if (item.last_byte) begin
				if (!res_valid && !given_q) begin
					res_valid  = 1'b1;
					res        = '0;
					res.status = whcp_pkg::ST_MISSING;
				end
				n_phase    = whcp_pkg::PH_RIFF;
				n_pos      = '0;
				n_tag      = '0;
				n_size     = '0;
				n_cend     = '0;
				n_body     = '0;
				n_fmt_seen = 1'b0;
				n_given    = 1'b0;
				n_afmt     = '0;
				n_chans    = '0;
				n_rate     = '0;
				n_bits     = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= whcp_pkg::PH_RIFF;
			pos_q      <= '0;
			tag_q      <= '0;
			size_q     <= '0;
			cend_q     <= '0;
			body_q     <= '0;
			fmt_seen_q <= 1'b0;
			given_q    <= 1'b0;
			afmt_q     <= '0;
			chans_q    <= '0;
			rate_q     <= '0;
			bits_q     <= '0;
		end else begin
			phase_q    <= n_phase;
			pos_q      <= n_pos;
			tag_q      <= n_tag;
			size_q     <= n_size;
			cend_q     <= n_cend;
			body_q     <= n_body;
			fmt_seen_q <= n_fmt_seen;
			given_q    <= n_given;
			afmt_q     <= n_afmt;
			chans_q    <= n_chans;
			rate_q     <= n_rate;
			bits_q     <= n_bits;
		end
	end

	`WHCP_ASSERT(a_phase_onehot, clk, arst_n, $onehot(phase_q))
	`WHCP_ASSERT(a_single_result, clk, arst_n, (take && given_q) |-> !res_valid)
	`WHCP_ASSERT(a_ok_needs_fmt, clk, arst_n, (res_valid && res.status == whcp_pkg::ST_OK) |-> fmt_seen_q)
	`WHCP_ASSERT(a_clear_on_last, clk, arst_n, (take && item.last_byte) |=> (pos_q == '0 && !given_q))
	`WHCP_ASSERT_NEVER(a_result_idle, clk, arst_n, res_valid && !take)

endmodule
`default_nettype wire

/* design/whcp_out_reg.sv */
// Result register of the WAV header parser, holding one result until taken.
// Depends on whcp_pkg for the result type.
`default_nettype none
module whcp_out_reg (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    take,
	input  wire                    res_valid,
	input  whcp_pkg::whcp_result_t res,
	input  wire                    m_tready,
	output logic                   m_tvalid,
	output whcp_pkg::whcp_result_t res_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take) begin
			m_tvalid <= res_valid;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule
`default_nettype wire

/* design/wav_header_chunk_parser.sv */
// Top level of the WAV header parser: size register, input stage, parser, result register.
// Depends on whcp_pkg, whcp_in_reg, whcp_parse and whcp_out_reg.
//
// Takes a WAV file one byte per request on the s_ side (s_tlast on the final
// byte of each buffer) and gives at most one result per buffer on the m_ side:
// status, fmt fields, data offset and data size. The buffer length is written
// through cfg_data beforehand; cfg_ready is always high. Throughput is one byte
// per clock, limited only by output back-pressure on the single result
// register; the completing byte is registered, then its result.
`default_nettype none
module wav_header_chunk_parser (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [7:0]                 s_tdata,  // data_byte [7:0]
	input  wire                        s_tlast,  // last_byte
	output logic                       m_tvalid,
	input  wire                        m_tready,
	// status [3:0], audio_format [19:4], channel_count [35:20], sample_rate [67:36],
	// sample_bits [83:68], data_offset [115:84], data_length [147:116], zero [151:148]
	output logic [whcp_pkg::OUT_W-1:0] m_tdata,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [31:0]                cfg_data
);

	logic [31:0]            buf_size_q;
	logic                   valid_s1;
	whcp_pkg::whcp_item_t   item_s1;
	logic                   take;
	logic                   res_valid;
	whcp_pkg::whcp_result_t res;
	whcp_pkg::whcp_result_t res_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q <= '0;
		end else if (cfg_valid) begin
			buf_size_q <= cfg_data;
		end
	end

	// a byte moves on unless an untaken result would be overwritten
	assign take = valid_s1 && (!m_tvalid || m_tready);

	whcp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	whcp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item_s1),
		.bsize     (buf_size_q),
		.res_valid (res_valid),
		.res       (res)
	);

	whcp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.res_valid (res_valid),
		.res       (res),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.res_s2    (res_s2)
	);

	assign m_tdata = {{(whcp_pkg::OUT_W - $bits(whcp_pkg::whcp_result_t)){1'b0}}, res_s2};

	`WHCP_ASSERT(a_cfg_sticks, clk, arst_n, (cfg_valid && cfg_ready) |=> (buf_size_q == $past(cfg_data)))

endmodule
`default_nettype wire
